### hw/rtl/rdfh_pkg.sv
// Shared types and constants for the ray and disk first hit block.
// Holds field widths, stream packing offsets, MAC opcodes and sequencer states.
// No dependencies.
`default_nettype none

package rdfh_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int DIR_W    = 16;
    localparam int LEN_W    = 23;
    localparam int TAG_W    = 16;
    localparam int CNT_W    = 7;
    localparam int SIG_W    = 16;
    localparam int OPND_W   = 29;
    localparam int ACC_W    = 58;
    localparam int RAD_W    = 56;
    localparam int ROOT_W   = 28;
    localparam int B_W      = 28;
    localparam int L_W      = 30;
    localparam int DIR_FRAC = 14;
    localparam int STEP_W   = 3;

    localparam int IN_W  = 168;
    localparam int OUT_W = 48;

    localparam int LIMIT_LSB = 0;
    localparam int WX_LSB    = 23;
    localparam int WY_LSB    = 47;
    localparam int NX_LSB    = 71;
    localparam int NY_LSB    = 95;
    localparam int UX_LSB    = 119;
    localparam int UY_LSB    = 135;
    localparam int TAG_LSB   = 151;

    localparam logic [SIG_W-1:0] CONTACT_DIST_RST = 16'd8192;
    localparam logic [24:0]      MAX_PARTICLES    = 25'd65536;
    localparam logic [CNT_W-1:0] COUNT_MAX        = '1;

    localparam logic [STEP_W-1:0] STEP_BX   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_BY   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CX   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CY   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SIG  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DISC = 3'd5;
    localparam logic [STEP_W-1:0] STEP_BCAP = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB,
        MAC_RSUB
    } mac_op_t;

    typedef struct packed {
        logic    issue;
        mac_op_t op;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_DECIDE
    } seq_state_t;

endpackage

`default_nettype wire

### hw/rtl/rdfh_mac.sv
// Shared multiply-accumulate unit with a registered product stage.
// An issued operation is registered with its product, then applied to the accumulator register.
// Depends on rdfh_pkg.
`default_nettype none

module rdfh_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rdfh_pkg::mac_ctl_t                     ctl,
    input  logic signed [rdfh_pkg::OPND_W-1:0]     opa,
    input  logic signed [rdfh_pkg::OPND_W-1:0]     opb,
    output logic signed [rdfh_pkg::ACC_W-1:0]      acc
);
    import rdfh_pkg::*;

    mac_ctl_t                  ctl_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    assign prod_next = ACC_W'(opa) * ACC_W'(opb);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_reg.issue)
        begin
            case (ctl_reg.op)
                MAC_LOAD: acc_next = prod_reg;
                MAC_ADD:  acc_next = acc_reg + prod_reg;
                MAC_SUB:  acc_next = acc_reg - prod_reg;
                MAC_RSUB: acc_next = prod_reg - acc_reg;
                default:  acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

### hw/rtl/rdfh_sqrt.sv
// Iterative integer square root, rounded down, one result bit per cycle.
// A start pulse loads the radicand; done pulses once the root is final.
// Depends on rdfh_pkg.
`default_nettype none

module rdfh_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rdfh_pkg::RAD_W-1:0]     rad,
    output logic                           done,
    output logic [rdfh_pkg::ROOT_W-1:0]    root
);
    import rdfh_pkg::*;

    localparam int SQ_CNT_W = $clog2(ROOT_W);
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(ROOT_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [SQ_CNT_W-1:0]    cnt_reg;
    logic [RAD_W-1:0]       rad_reg;
    logic [ROOT_W+1:0]      rem_reg;
    logic [ROOT_W+1:0]      rem_next;
    logic [ROOT_W-1:0]      root_reg;
    logic [ROOT_W-1:0]      root_next;
    logic [ROOT_W+3:0]      rem_sh;
    logic [ROOT_W+3:0]      trial;
    logic [ROOT_W+3:0]      diff;
    logic                   fits;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
        if (fits)
        begin
            rem_next  = diff[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### hw/rtl/ray_disk_first_hit.sv
// Nearest first-contact search of a walker's ray against candidate disks.
// Top level: stream ports, sequencer, shared MAC and square root unit.
// Depends on rdfh_pkg, rdfh_mac and rdfh_sqrt.
//
// Usage: each request on the s_ channel is one candidate neighbor disk. With
// s_tuser high the request starts a new query, loading the limit and clearing
// the hit flag, count and tag before its own candidate is tested. Every request
// yields exactly one result on the m_ channel with the running best length,
// tag, count and the hit flag. The contact distance is written on the cfg_
// channel, which is always ready, and should only change while the block idles.
// Sequencing: one request is in flight at a time. The shared MAC first forms
// b and the discriminant, then the root unit finds the root, one root bit per
// cycle over 28 bits, and the result is registered for the m_ channel; the
// next request is taken once the sequencer is back in idle. With a negative
// discriminant the root is skipped. While the receiver stalls the result
// stays in the output register; the next request is still accepted and runs
// until its own result would overwrite it, where the sequencer waits.
// Reset clears the query state and output valid, and sets the contact
// distance to 2.0.
`default_nettype none

module ray_disk_first_hit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // limit, walker_x, walker_y, neighbor_x, neighbor_y, dir_x, dir_y,
    // disk tag, one zero pad bit
    input  logic [rdfh_pkg::IN_W-1:0]     s_tdata,
    // first
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_length, hit_tag, hit_count, two zero pad bits
    output logic [rdfh_pkg::OUT_W-1:0]    m_tdata,
    // hit_found
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rdfh_pkg::SIG_W-1:0]    cfg_data
);
    import rdfh_pkg::*;

    seq_state_t                 state_reg;
    seq_state_t                 state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [SIG_W-1:0]           sig_reg;

    logic signed [DIFF_W-1:0]   dx_reg;
    logic signed [DIFF_W-1:0]   dy_reg;
    logic signed [DIR_W-1:0]    ux_reg;
    logic signed [DIR_W-1:0]    uy_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic                       tagok_reg;
    logic signed [B_W-1:0]      b_reg;
    logic                       dneg_reg;

    logic [LEN_W-1:0]           best_len_reg;
    logic [LEN_W-1:0]           best_len_next;
    logic [TAG_W-1:0]           best_tag_reg;
    logic [TAG_W-1:0]           best_tag_next;
    logic                       found_reg;
    logic                       found_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    logic                       m_tvalid_reg;
    logic [LEN_W-1:0]           out_len_reg;
    logic [TAG_W-1:0]           out_tag_reg;
    logic                       out_found_reg;
    logic [CNT_W-1:0]           out_count_reg;

    logic                       in_take;
    logic                       dec_fire;
    logic                       sq_start;
    logic                       sq_done;
    logic [ROOT_W-1:0]          sq_root;
    mac_ctl_t                   mac_ctl;
    logic signed [OPND_W-1:0]   mac_a;
    logic signed [OPND_W-1:0]   mac_b;
    logic signed [ACC_W-1:0]    mac_acc;
    logic signed [DIFF_W-1:0]   in_dx;
    logic signed [DIFF_W-1:0]   in_dy;

    logic signed [L_W-1:0]      root_s;
    logic signed [L_W-1:0]      sum_bs;
    logic signed [L_W-1:0]      len_l;
    logic                       hit;

    assign cfg_ready = 1'b1;
    assign in_take   = s_tvalid && s_tready;

    assign in_dx = DIFF_W'($signed(s_tdata[WX_LSB +: COORD_W]))
                 - DIFF_W'($signed(s_tdata[NX_LSB +: COORD_W]));
    assign in_dy = DIFF_W'($signed(s_tdata[WY_LSB +: COORD_W]))
                 - DIFF_W'($signed(s_tdata[NY_LSB +: COORD_W]));

    rdfh_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .opa   (mac_a),
        .opb   (mac_b),
        .acc   (mac_acc)
    );

    rdfh_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (mac_acc[RAD_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = mac_acc[ACC_W-1] ? ST_DECIDE : ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and MAC operand schedule.
    always_comb
    begin
        s_tready = 1'b0;
        sq_start = 1'b0;
        dec_fire = 1'b0;
        mac_ctl  = '0;
        mac_a    = OPND_W'(dx_reg);
        mac_b    = OPND_W'(dx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_MUL:
            begin
                case (step_reg)
                    STEP_BX:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_LOAD};
                        mac_a   = OPND_W'(ux_reg);
                        mac_b   = OPND_W'(dx_reg);
                    end
                    STEP_BY:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_ADD};
                        mac_a   = OPND_W'(uy_reg);
                        mac_b   = OPND_W'(dy_reg);
                    end
                    STEP_CX:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_LOAD};
                        mac_a   = OPND_W'(dx_reg);
                        mac_b   = OPND_W'(dx_reg);
                    end
                    STEP_CY:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_ADD};
                        mac_a   = OPND_W'(dy_reg);
                        mac_b   = OPND_W'(dy_reg);
                    end
                    STEP_SIG:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_SUB};
                        mac_a   = $signed(OPND_W'(sig_reg));
                        mac_b   = $signed(OPND_W'(sig_reg));
                    end
                    STEP_DISC:
                    begin
                        mac_ctl = '{issue: 1'b1, op: MAC_RSUB};
                        mac_a   = OPND_W'(b_reg);
                        mac_b   = OPND_W'(b_reg);
                    end
                    default:
                    begin
                        mac_ctl = '0;
                    end
                endcase
                if (step_reg == STEP_LAST)
                begin
                    sq_start = !mac_acc[ACC_W-1];
                end
            end
            ST_DECIDE:
            begin
                dec_fire = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The nearest positive root and the update of the query state.
    always_comb
    begin
        root_s = $signed(L_W'(sq_root));
        sum_bs = L_W'(b_reg) + root_s;
        if (sum_bs < 0)
        begin
            len_l = -sum_bs;
        end
        else
        begin
            len_l = root_s - L_W'(b_reg);
        end
        hit = tagok_reg && !dneg_reg && (len_l > 0)
           && (len_l <= $signed(L_W'(best_len_reg)));

        best_len_next = best_len_reg;
        best_tag_next = best_tag_reg;
        found_next    = found_reg;
        count_next    = count_reg;
        if (hit)
        begin
            best_len_next = len_l[LEN_W-1:0];
            best_tag_next = tag_reg;
            found_next    = 1'b1;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            sig_reg      <= CONTACT_DIST_RST;
            best_len_reg <= '0;
            best_tag_reg <= '0;
            found_reg    <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                sig_reg <= cfg_data;
            end
            if (in_take)
            begin
                step_reg <= '0;
                if (s_tuser)
                begin
                    best_len_reg <= s_tdata[LIMIT_LSB +: LEN_W];
                    best_tag_reg <= '0;
                    found_reg    <= 1'b0;
                    count_reg    <= '0;
                end
            end
            else if (state_reg == ST_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (dec_fire)
            begin
                best_len_reg <= best_len_next;
                best_tag_reg <= best_tag_next;
                found_reg    <= found_next;
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
            ux_reg    <= $signed(s_tdata[UX_LSB +: DIR_W]);
            uy_reg    <= $signed(s_tdata[UY_LSB +: DIR_W]);
            tag_reg   <= s_tdata[TAG_LSB +: TAG_W];
            tagok_reg <= (25'(s_tdata[TAG_LSB +: TAG_W]) < MAX_PARTICLES);
        end
        if ((state_reg == ST_MUL) && (step_reg == STEP_BCAP))
        begin
            b_reg <= mac_acc[DIR_FRAC +: B_W];
        end
        if ((state_reg == ST_MUL) && (step_reg == STEP_LAST))
        begin
            dneg_reg <= mac_acc[ACC_W-1];
        end
        if (dec_fire)
        begin
            out_len_reg   <= best_len_next;
            out_tag_reg   <= best_tag_next;
            out_found_reg <= found_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_tag_reg, out_len_reg};

    a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("Root unit finished outside the root phase.");

    a_stall_holds_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_DECIDE))
        else $error("Sequencer left the decide phase while the output was held.");

    a_found_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (count_reg != '0))
        else $error("Hit flag set with a zero hit count.");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_take && s_tuser) |=> (count_reg >= $past(count_reg)))
        else $error("Hit count dropped without a new query.");

endmodule

`default_nettype wire

### tb/sv/tb_ray_disk_first_hit.sv
`timescale 1ns / 100ps
// Self-checking testbench for ray_disk_first_hit: streams candidate disks and checks
// every result against a predictor held in a small scoreboard class.
// Depends on rdfh_pkg and the ray_disk_first_hit RTL.

import rdfh_pkg::*;

typedef struct {
    logic                      first;
    logic [LEN_W-1:0]          limit;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [DIR_W-1:0]   ux;
    logic signed [DIR_W-1:0]   uy;
    logic [TAG_W-1:0]          tag;
} candidate_t;

typedef struct {
    logic             found;
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
} outcome_t;

class first_hit_tracker;
    logic [SIG_W-1:0] sigma;
    logic [LEN_W-1:0] best_len;
    logic [TAG_W-1:0] best_tag;
    logic             found;
    logic [CNT_W-1:0] hits;
    outcome_t         expected_q[$];
    int               errors;

    function new();
        sigma = CONTACT_DIST_RST;
        best_len = '0;
        best_tag = '0;
        found = 1'b0;
        hits = '0;
        errors = 0;
    endfunction

    // Nearest positive root of l^2 + 2bl + C = 0 with a floored square root.
    function void note_candidate(candidate_t c);
        longint dx;
        longint dy;
        longint b;
        longint cc;
        longint disc;
        longint rem;
        longint root;
        longint bitv;
        longint l;
        outcome_t o;
        if (c.first)
        begin
            best_len = c.limit;
            found = 1'b0;
            hits = '0;
            best_tag = '0;
        end
        dx = longint'(c.wx) - longint'(c.nx);
        dy = longint'(c.wy) - longint'(c.ny);
        b = (longint'(c.ux) * dx + longint'(c.uy) * dy) >>> DIR_FRAC;
        cc = dx * dx + dy * dy - longint'(sigma) * longint'(sigma);
        disc = b * b - cc;
        if (disc >= 0)
        begin
            rem = disc;
            root = 0;
            bitv = longint'(1) << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= root + bitv)
                begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            if (b + root < 0)
                l = -b - root;
            else
                l = -b + root;
            if (l > 0 && l <= longint'(best_len))
            begin
                found = 1'b1;
                best_len = l[LEN_W-1:0];
                best_tag = c.tag;
                if (hits != COUNT_MAX)
                    hits = hits + 1'b1;
            end
        end
        o.found = found;
        o.length = best_len;
        o.tag = best_tag;
        o.count = hits;
        expected_q.push_back(o);
    endfunction

    function void check_outcome(outcome_t got);
        outcome_t want;
        if (expected_q.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.found !== want.found)
        begin
            $error("hit_found expected %0d actual %0d", want.found, got.found);
            errors++;
        end
        if (got.length !== want.length)
        begin
            $error("hit_length expected %0d actual %0d", want.length, got.length);
            errors++;
        end
        if (got.tag !== want.tag)
        begin
            $error("hit_tag expected %0d actual %0d", want.tag, got.tag);
            errors++;
        end
        if (got.count !== want.count)
        begin
            $error("hit_count expected %0d actual %0d", want.count, got.count);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_ray_disk_first_hit;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_REQUESTS = 180;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIG_W-1:0]   cfg_data;

    first_hit_tracker   tracker;
    int                 send_idle;
    int                 recv_idle;
    int                 sig_now;
    int                 sent_requests;
    int                 cycles = 0;

    ray_disk_first_hit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found = m_tuser;
            got.length = m_tdata[LEN_W-1:0];
            got.tag = m_tdata[LEN_W +: TAG_W];
            got.count = m_tdata[LEN_W+TAG_W +: CNT_W];
            tracker.check_outcome(got);
        end
    end

    function automatic candidate_t mk(input bit first, input int limit, input int wx,
                                      input int wy, input int nx, input int ny,
                                      input int ux, input int uy, input int tag);
        candidate_t c;
        c.first = first;
        c.limit = limit[LEN_W-1:0];
        c.wx = wx[COORD_W-1:0];
        c.wy = wy[COORD_W-1:0];
        c.nx = nx[COORD_W-1:0];
        c.ny = ny[COORD_W-1:0];
        c.ux = ux[DIR_W-1:0];
        c.uy = uy[DIR_W-1:0];
        c.tag = tag[TAG_W-1:0];
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input candidate_t c);
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.first;
        s_tdata <= {1'b0, c.tag, c.uy, c.ux, c.ny, c.nx, c.wy, c.wx, c.limit};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_candidate(c);
        sent_requests++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_contact_dist(input int v);
        cfg_valid <= 1'b1;
        cfg_data <= v[SIG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.sigma = v[SIG_W-1:0];
        sig_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The same on-axis disk again and again: every repeat ties with the
    // current length, so the count climbs and saturates on long runs.
    task automatic axis_run(input int n);
        candidate_t c;
        int k;
        c = mk(1'b1, 8388607, 0, 0, 3 * sig_now + 4096, 0, 16384, 0, 0);
        for (k = 0; k < n; k++)
        begin
            c.tag = k[TAG_W-1:0];
            send_request(c);
            c.first = 1'b0;
        end
    endtask

    task automatic noise_request();
        candidate_t c;
        logic [31:0] r;
        c.first = ($urandom_range(0, 3) == 0);
        r = $urandom;
        c.limit = r[LEN_W-1:0];
        r = $urandom;
        c.wx = r[COORD_W-1:0];
        r = $urandom;
        c.wy = r[COORD_W-1:0];
        r = $urandom;
        c.nx = r[COORD_W-1:0];
        r = $urandom;
        c.ny = r[COORD_W-1:0];
        r = $urandom;
        c.ux = r[DIR_W-1:0];
        c.uy = r[31:16];
        r = $urandom;
        c.tag = r[TAG_W-1:0];
        send_request(c);
    endtask

    // One walker and direction, several neighbors placed around its ray so that
    // hits, misses, disks behind and overlapping disks all occur.
    task automatic run_query(input bit with_first);
        candidate_t c;
        logic [31:0] r;
        int lim;
        int wx_i;
        int wy_i;
        int ux_i;
        int uy_i;
        int n;
        int k;
        int t;
        int p;
        int pr;
        real a;
        longint nxl;
        longint nyl;
        case ($urandom_range(0, 3))
            0: lim = 8388607;
            1: lim = $urandom_range(0, 8388607);
            default: lim = $urandom_range(0, 8 * sig_now + 16384);
        endcase
        wx_i = int'($urandom_range(0, 8388608)) - 4194304;
        wy_i = int'($urandom_range(0, 8388608)) - 4194304;
        a = $urandom_range(0, 62831) / 10000.0;
        ux_i = $rtoi($cos(a) * 16384.0);
        uy_i = $rtoi($sin(a) * 16384.0);
        c = mk(with_first, lim, wx_i, wy_i, 0, 0, ux_i, uy_i, 0);
        n = $urandom_range(1, 12);
        pr = sig_now + sig_now / 4 + 64;
        for (k = 0; k < n; k++)
        begin
            if (k == 0 || $urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    t = $urandom_range(0, 1 << 20);
                else
                    t = $urandom_range(0, 8 * sig_now + 32768);
                if ($urandom_range(0, 7) == 0)
                    t = -t;
                p = int'($urandom_range(0, 2 * pr)) - pr;
                nxl = longint'(wx_i) + ((longint'(t) * ux_i - longint'(p) * uy_i) >>> DIR_FRAC);
                nyl = longint'(wy_i) + ((longint'(t) * uy_i + longint'(p) * ux_i) >>> DIR_FRAC);
                c.nx = nxl[COORD_W-1:0];
                c.ny = nyl[COORD_W-1:0];
            end
            r = $urandom;
            c.tag = r[TAG_W-1:0];
            send_request(c);
            c.first = 1'b0;
        end
    endtask

    initial
    begin
        int ph;
        int start;
        int pick;
        tracker = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sent_requests = 0;
        sig_now = int'(CONTACT_DIST_RST);
        send_idle = 12;
        recv_idle = 62;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests under the reset contact distance.
        send_request(mk(0, 0, 0, 0, 40000, 0, 16384, 0, 1));
        send_request(mk(1, 8388607, 0, 0, 40000, 0, 16384, 0, 2));
        send_request(mk(0, 0, 0, 0, 40000, 0, 16384, 0, 3));
        send_request(mk(0, 0, 0, 0, 20000, 0, 16384, 0, 4));
        send_request(mk(0, 0, 0, 0, 40000, 0, 16384, 0, 5));
        send_request(mk(0, 0, 0, 0, -40000, 0, 16384, 0, 6));
        send_request(mk(0, 0, 0, 0, 1000, 0, 16384, 0, 7));
        send_request(mk(0, 0, 0, 0, 30000, 20000, 16384, 0, 8));
        send_request(mk(1, 0, 8388607, 8388607, -8388608, -8388608, -16384, -16384, 9));
        send_request(mk(1, 8388607, -8388608, -8388608, 8388607, 8388607, 16384, 16384,
                        65535));
        send_request(mk(1, 8388607, 100000, -50000, 120000, -30000, -32768, 32767, 10));
        send_request(mk(1, 100000, 0, 0, 4000, 0, 0, 0, 11));
        send_request(mk(0, 0, 0, 0, 4000, 0, 0, 0, 0));
        send_request(mk(1, 1, 0, 0, 40000, 0, 16384, 0, 12));
        send_request(mk(1, 31808, 0, 0, 40000, 0, 16384, 0, 13));
        send_request(mk(0, 0, 0, 0, 0, 0, 16384, 0, 14));
        send_request(mk(1, 8388607, 0, 0, 0, -50000, 0, -16384, 15));

        for (ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            case (ph)
                0: pick = 0;
                1: pick = 65535;
                2: pick = 8192;
                3: pick = $urandom_range(1, 65534);
                default: pick = 20000;
            endcase
            write_contact_dist(pick);
            if (ph < 2)
            begin
                send_idle = 12;
                recv_idle = 62;
            end
            else if (ph < 4)
            begin
                send_idle = 62;
                recv_idle = 12;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            start = sent_requests;
            axis_run((ph == 2) ? 135 : 3);
            while (sent_requests - start < PHASE_REQUESTS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    noise_request();
                else
                    run_query(pick >= 16);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
